// ===== rtl/qte_pkg.sv =====
// Package for the quaternion to Euler angle converter.
// Holds operand widths, the shared operand struct and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package qte_pkg;

    localparam int OP_W      = 34;   // atan2 operands, Q.28 with headroom
    localparam int S_W       = 30;   // saturated pitch sine, +-2^28
    localparam int CW        = 38;   // CORDIC x/y datapath
    localparam int ACC_W     = 34;   // angle accumulator, 2^32 counts per turn
    localparam int SQ_IN_W   = 57;   // radicand, up to 2^56
    localparam int SQ_STEPS  = 29;   // one root bit per stage
    localparam int ROOT_W    = 29;   // root up to 2^28
    localparam int ATAN_LEN  = 24;
    localparam int ANGLE_W   = 16;
    localparam int QUAT_W    = 16;
    localparam int PROD_W    = 32;

    typedef logic signed [OP_W-1:0]    op_t;
    typedef logic signed [S_W-1:0]     sine_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef struct packed {
        op_t   rn;
        op_t   rd;
        op_t   yn;
        op_t   yd;
        sine_t s;
    } ops_t;

    localparam acc_t ONE_Q28   = acc_t'(64'sd268435456);
    localparam acc_t HALF_TURN = acc_t'(64'sd2147483648);

    localparam acc_t ATAN_TAB [ATAN_LEN] = '{
        acc_t'(34'h020000000), acc_t'(34'h012E4051D), acc_t'(34'h009FB385B),
        acc_t'(34'h0051111D4), acc_t'(34'h0028B0D43), acc_t'(34'h00145D7E1),
        acc_t'(34'h000A2F61E), acc_t'(34'h000517C55), acc_t'(34'h00028BE53),
        acc_t'(34'h000145F2E), acc_t'(34'h0000A2F98), acc_t'(34'h0000517CC),
        acc_t'(34'h000028BE6), acc_t'(34'h0000145F3), acc_t'(34'h00000A2F9),
        acc_t'(34'h00000517C), acc_t'(34'h0000028BE), acc_t'(34'h00000145F),
        acc_t'(34'h000000A2F), acc_t'(34'h000000517), acc_t'(34'h00000028B),
        acc_t'(34'h000000145), acc_t'(34'h0000000A2), acc_t'(34'h000000051)
    };

endpackage

`default_nettype wire

// ===== rtl/qte_quat_if.sv =====
// Input channel of the quaternion to Euler angle converter.
// Carries valid, ready and one quaternion; uses qte_pkg.
`default_nettype none

interface qte_quat_if;
    logic               valid;
    logic               ready;
    qte_pkg::quat_t     quat_w;
    qte_pkg::quat_t     quat_x;
    qte_pkg::quat_t     quat_y;
    qte_pkg::quat_t     quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

// ===== rtl/qte_euler_if.sv =====
// Output channel of the quaternion to Euler angle converter.
// Carries valid, ready and roll, pitch, yaw; uses qte_pkg.
`default_nettype none

interface qte_euler_if;
    logic               valid;
    logic               ready;
    qte_pkg::angle_t    roll_angle;
    qte_pkg::angle_t    pitch_angle;
    qte_pkg::angle_t    yaw_angle;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

`default_nettype wire

// ===== rtl/qte_isqrt.sv =====
// Pipelined integer square root, floor(sqrt(v)), one root bit per stage.
// Depends on qte_pkg.
`default_nettype none

module qte_isqrt (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [qte_pkg::SQ_IN_W-1:0]  radicand,
    output logic      [qte_pkg::ROOT_W-1:0]   root
);
    import qte_pkg::*;

    localparam int RES_W = SQ_IN_W + 1;

    logic [SQ_IN_W-1:0] rem_reg [SQ_STEPS+1];
    logic [RES_W-1:0]   res_reg [SQ_STEPS+1];

    always_comb
    begin
        rem_reg[0] = radicand;
        res_reg[0] = '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        localparam int SH = 2 * (SQ_STEPS - 1 - k);
        logic [RES_W-1:0]   bit_w;
        logic [RES_W-1:0]   sum;
        logic [SQ_IN_W-1:0] rem_next;
        logic [RES_W-1:0]   res_next;

        always_comb
        begin
            bit_w = RES_W'(1) << SH;
            sum   = res_reg[k] + bit_w;
            if ({1'b0, rem_reg[k]} >= sum)
            begin
                rem_next = rem_reg[k] - sum[SQ_IN_W-1:0];
                res_next = (res_reg[k] >> 1) + bit_w;
            end
            else
            begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
            end
        end
    end

    assign root = res_reg[SQ_STEPS][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2, one micro-rotation per stage.
// Depends on qte_pkg; returns a 16-bit binary angle.
`default_nettype none

module qte_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire qte_pkg::op_t     y_in,
    input  wire qte_pkg::op_t     x_in,
    output qte_pkg::angle_t       angle
);
    import qte_pkg::*;

    typedef logic signed [CW-1:0] cw_t;

    cw_t  x_reg    [STEPS+1];
    cw_t  y_reg    [STEPS+1];
    acc_t acc_reg  [STEPS+1];
    logic zero_reg [STEPS+1];

    cw_t  x_pre;
    cw_t  y_pre;
    acc_t acc_pre;
    logic zero_pre;

    // pre-rotation by pi for a negative x operand
    always_comb
    begin
        zero_pre = (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            acc_pre = (y_in >= 0) ? HALF_TURN : -HALF_TURN;
            x_pre   = -cw_t'(x_in);
            y_pre   = -cw_t'(y_in);
        end
        else
        begin
            acc_pre = '0;
            x_pre   = cw_t'(x_in);
            y_pre   = cw_t'(y_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_pre;
            y_reg[0]    <= y_pre;
            acc_reg[0]  <= acc_pre;
            zero_reg[0] <= zero_pre;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        cw_t  xs;
        cw_t  ys;
        cw_t  x_next;
        cw_t  y_next;
        acc_t acc_next;

        always_comb
        begin
            xs = x_reg[k] >>> k;
            ys = y_reg[k] >>> k;
            if (y_reg[k] >= 0)
            begin
                x_next   = x_reg[k] + ys;
                y_next   = y_reg[k] - xs;
                acc_next = acc_reg[k] + ATAN_TAB[k];
            end
            else
            begin
                x_next   = x_reg[k] - ys;
                y_next   = y_reg[k] + xs;
                acc_next = acc_reg[k] - ATAN_TAB[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                acc_reg[k+1]  <= acc_next;
                zero_reg[k+1] <= zero_reg[k];
            end
        end
    end

    acc_t rounded;

    always_comb
    begin
        rounded = acc_reg[STEPS] + acc_t'(32768);
        angle   = zero_reg[STEPS] ? '0 : angle_t'(rounded[31:16]);
    end

endmodule

`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
// Quaternion to roll/pitch/yaw converter, top level.
// Depends on qte_pkg, qte_quat_if, qte_euler_if, qte_isqrt and qte_cordic.
//
// Usage:
//   quat  : sink channel, one Q1.14 quaternion (w, x, y, z) per transaction.
//   euler : source channel, roll, pitch and yaw as 16-bit binary angles
//           (65536 counts per turn), one transaction per quaternion, in order.
// Throughput: one quaternion per clock cycle when euler is not stalled.
// Pipeline: registers for products, sums, pitch sine square and radicand, then
//   the bit-per-stage square root, the CORDIC pre-rotation, a register for each
//   CORDIC step (CORDIC_STEPS capped at 24) and the output register.
// Stall: when a result waits on the output and euler.ready is low, the whole
//   pipeline holds and quat.ready is low; nothing is dropped or repeated.
// Reset: rst_n clears all valid bits; the data registers are not reset.
`default_nettype none

module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    qte_quat_if.sink        quat,
    qte_euler_if.source     euler
);
    import qte_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int DL    = SQ_STEPS + 2;
    localparam int LAT   = STEPS + SQ_STEPS + 6;

    logic           advance;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign advance     = !vld_reg[LAT-1] || euler.ready;
    assign quat.ready  = advance;
    assign euler.valid = vld_reg[LAT-1];

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], quat.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    // stage 1: products
    prod_t p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    prod_t p_wz_reg, p_xy_reg, p_wy_reg, p_zx_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_wx_reg <= quat.quat_w * quat.quat_x;
            p_yz_reg <= quat.quat_y * quat.quat_z;
            p_xx_reg <= quat.quat_x * quat.quat_x;
            p_yy_reg <= quat.quat_y * quat.quat_y;
            p_zz_reg <= quat.quat_z * quat.quat_z;
            p_wz_reg <= quat.quat_w * quat.quat_z;
            p_xy_reg <= quat.quat_x * quat.quat_y;
            p_wy_reg <= quat.quat_w * quat.quat_y;
            p_zx_reg <= quat.quat_z * quat.quat_x;
        end
    end

    // stage 2: atan2 operands and saturated pitch sine
    ops_t ops_next;
    ops_t ops_reg;
    op_t  s_full;

    always_comb
    begin
        ops_next.rn = (op_t'(p_wx_reg) + op_t'(p_yz_reg)) <<< 1;
        ops_next.rd = op_t'(ONE_Q28) - ((op_t'(p_xx_reg) + op_t'(p_yy_reg)) <<< 1);
        ops_next.yn = (op_t'(p_wz_reg) + op_t'(p_xy_reg)) <<< 1;
        ops_next.yd = op_t'(ONE_Q28) - ((op_t'(p_yy_reg) + op_t'(p_zz_reg)) <<< 1);
        s_full      = (op_t'(p_wy_reg) - op_t'(p_zx_reg)) <<< 1;
        if (s_full > op_t'(ONE_Q28))
            ops_next.s = sine_t'(ONE_Q28);
        else if (s_full < -op_t'(ONE_Q28))
            ops_next.s = -sine_t'(ONE_Q28);
        else
            ops_next.s = sine_t'(s_full);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            ops_reg <= ops_next;
    end

    // stages 3 and 4: sine square, then radicand 1 - s^2
    logic signed [2*S_W-1:0] sq_full;
    logic [SQ_IN_W-1:0]      sq_reg;
    logic [SQ_IN_W-1:0]      rad_reg;

    assign sq_full = ops_reg.s * ops_reg.s;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg  <= sq_full[SQ_IN_W-1:0];
            rad_reg <= (SQ_IN_W'(1) << (SQ_IN_W - 1)) - sq_reg;
        end
    end

    // operands wait alongside the square root
    ops_t dl_reg [DL];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dl_reg[0] <= ops_reg;
            for (int i = 1; i < DL; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    logic [ROOT_W-1:0] cos_root;

    qte_isqrt u_isqrt (
        .clk      (clk),
        .en       (advance),
        .radicand (rad_reg),
        .root     (cos_root)
    );

    angle_t roll_a;
    angle_t pitch_a;
    angle_t yaw_a;

    qte_cordic #(.STEPS(STEPS)) u_roll (
        .clk   (clk),
        .en    (advance),
        .y_in  (dl_reg[DL-1].rn),
        .x_in  (dl_reg[DL-1].rd),
        .angle (roll_a)
    );

    qte_cordic #(.STEPS(STEPS)) u_pitch (
        .clk   (clk),
        .en    (advance),
        .y_in  (op_t'(dl_reg[DL-1].s)),
        .x_in  (op_t'({1'b0, cos_root})),
        .angle (pitch_a)
    );

    qte_cordic #(.STEPS(STEPS)) u_yaw (
        .clk   (clk),
        .en    (advance),
        .y_in  (dl_reg[DL-1].yn),
        .x_in  (dl_reg[DL-1].yd),
        .angle (yaw_a)
    );

    // output register with pitch clamp
    localparam angle_t QUARTER = angle_t'(16384);

    angle_t roll_reg;
    angle_t pitch_reg;
    angle_t yaw_reg;
    angle_t pitch_next;

    always_comb
    begin
        if (pitch_a > QUARTER)
            pitch_next = QUARTER;
        else if (pitch_a < -QUARTER)
            pitch_next = -QUARTER;
        else
            pitch_next = pitch_a;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            roll_reg  <= roll_a;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_a;
        end
    end

    assign euler.roll_angle  = roll_reg;
    assign euler.pitch_angle = pitch_reg;
    assign euler.yaw_angle   = yaw_reg;

`ifndef SYNTHESIS
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (pitch_reg <= QUARTER) && (pitch_reg >= -QUARTER))
        else $error("pitch out of range");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        quat.ready == (!vld_reg[LAT-1] || euler.ready))
        else $error("ready does not follow output state");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_quaternion_to_euler_angles.sv =====
// Testbench for quaternion_to_euler_angles: directed and random quaternions, mostly with
// random idling on both channels, checked against an in-bench fixed-point CORDIC model.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and the RTL top level.
`default_nettype none

module tb_quaternion_to_euler_angles;
    timeunit 1ns;
    timeprecision 1ps;
    import qte_pkg::*;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 35;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        angle_t roll;
        angle_t pitch;
        angle_t yaw;
    } euler_t;

    localparam longint ARCTAN [24] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
        64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    qte_quat_if  quat();
    qte_euler_if euler();

    quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) uut (
        .clk(clk), .rst_n(rst_n), .quat(quat.sink), .euler(euler.source)
    );

    euler_t expected_angles[$];
    int errors = 0;
    int idle_cycles = 0;
    bit sender_idle_on = 1'b1;
    bit receiver_idle_on = 1'b1;
    int hold_off_cycles = 0;
    int recv_idle = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else res >>= 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint acc;
        longint xs;
        longint ys;
        longint r;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            acc = (y >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc += ARCTAN[i];
            end
            else begin
                x = x - ys;
                y = y + xs;
                acc -= ARCTAN[i];
            end
        end
        r = (acc + 32768) >>> 16;
        return longint'($signed(r[15:0]));
    endfunction

    function automatic euler_t euler_of(quat_t qw, quat_t qx, quat_t qy, quat_t qz);
        longint w, x, y, z, s, c, p;
        longint one;
        euler_t e;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 <<< 28;
        s = 2 * (w * y - z * x);
        if (s > one) s = one;
        if (s < -one) s = -one;
        c = floor_sqrt(longint'((64'sd1 <<< 56) - s * s));
        p = cordic_angle(s, c);
        if (p > 16384) p = 16384;
        if (p < -16384) p = -16384;
        e.roll = angle_t'(cordic_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
        e.pitch = angle_t'(p);
        e.yaw = angle_t'(cordic_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
        return e;
    endfunction

    task automatic report_mismatch(string what, angle_t got, angle_t want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_quat(quat_t w, quat_t x, quat_t y, quat_t z);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            quat.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quat.valid <= 1'b1;
        quat.quat_w <= w;
        quat.quat_x <= x;
        quat.quat_y <= y;
        quat.quat_z <= z;
        @(posedge clk);
        while (!quat.ready) @(posedge clk);
        expected_angles.push_back(euler_of(w, x, y, z));
    endtask

    function automatic quat_t rand_component();
        return quat_t'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic test_directed();
        quat_t v[5] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585};
        send_quat(16'sd16384, '0, '0, '0);
        send_quat('0, '0, '0, '0);
        send_quat('0, 16'sd16384, '0, '0);
        send_quat('0, '0, 16'sd16384, '0);
        send_quat('0, '0, '0, 16'sd16384);
        send_quat(16'sd11585, '0, 16'sd11585, '0);
        send_quat(16'sd11585, '0, -16'sd11585, '0);
        send_quat(16'sd16384, '0, 16'sd16384, '0);
        send_quat('0, '0, '0, -16'sd16384);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_quat(16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
        send_quat(16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh0001);
        for (int i = 0; i < 10; i++)
            send_quat(v[i % 5], v[(i + 1) % 5], v[(i + 3) % 5], v[(i + 2) % 5]);
    endtask

    task automatic test_unit_random(int n);
        real a, b, c, d, m;
        for (int i = 0; i < n; i++) begin
            a = $itor($signed($urandom_range(0, 2000)) - 1000);
            b = $itor($signed($urandom_range(0, 2000)) - 1000);
            c = $itor($signed($urandom_range(0, 2000)) - 1000);
            d = $itor($signed($urandom_range(0, 2000)) - 1000);
            m = $sqrt(a * a + b * b + c * c + d * d);
            if (m < 1.0) begin
                a = 1000.0;
                m = 1000.0;
            end
            send_quat(quat_t'($rtoi(16384.0 * a / m)), quat_t'($rtoi(16384.0 * b / m)),
                      quat_t'($rtoi(16384.0 * c / m)), quat_t'($rtoi(16384.0 * d / m)));
        end
    endtask

    task automatic test_raw_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1))
                send_quat(quat_t'($urandom), quat_t'($urandom), quat_t'($urandom),
                          quat_t'($urandom));
            else
                send_quat(rand_component(), rand_component(), rand_component(),
                          rand_component());
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 300;
        sender_idle_on = 1'b0;
        for (int i = 0; i < 150; i++)
            send_quat(rand_component(), rand_component(), rand_component(), rand_component());
        sender_idle_on = 1'b1;
    endtask

    task automatic test_full_rate(int n);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        test_unit_random(n);
    endtask

    always @(posedge clk) begin
        if (!rst_n) euler.ready <= 1'b0;
        else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            euler.ready <= 1'b0;
        end
        else if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            euler.ready <= 1'b0;
        end
        else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
            recv_idle <= $urandom_range(0, 17);
            euler.ready <= 1'b0;
        end
        else euler.ready <= 1'b1;
    end

    always @(posedge clk) begin
        euler_t want;
        if (rst_n && euler.valid && euler.ready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected transaction", euler.roll_angle, '0);
            end
            else begin
                want = expected_angles.pop_front();
                if (euler.roll_angle !== want.roll)
                    report_mismatch("roll", euler.roll_angle, want.roll);
                if (euler.pitch_angle !== want.pitch)
                    report_mismatch("pitch", euler.pitch_angle, want.pitch);
                if (euler.yaw_angle !== want.yaw)
                    report_mismatch("yaw", euler.yaw_angle, want.yaw);
            end
        end
    end

    always @(posedge clk) begin
        if ((quat.valid && quat.ready) || (euler.valid && euler.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        quat.valid = 1'b0;
        quat.quat_w = '0;
        quat.quat_x = '0;
        quat.quat_y = '0;
        quat.quat_z = '0;
        euler.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_unit_random(900);
        test_backpressure();
        test_raw_random(600);
        test_full_rate(280);
        quat.valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && expected_angles.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/qte_pkg.sv
rtl/qte_quat_if.sv
rtl/qte_euler_if.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles.sv
tb/tb_quaternion_to_euler_angles.sv
